FILE: hw/rtl/lrup_pkg.sv
// Shared types, constants and helper functions of the LRU page replacement core.
`default_nettype none
package lrup_pkg;

  // Configuration register file layout.
  localparam int FRAMES_W = 7;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_FRAMES_IN_USE = 1'b0;
  localparam logic [FRAMES_W-1:0] FRAMES_RESET = 7'd64;

  // Width of the reported evicted page number and of the running counters.
  localparam int EVPAGE_W = 20;
  localparam int COUNT_W = 32;

  // One memory access.
  typedef struct packed {
    logic [31:0] address;
    logic        is_write;
  } in_item_t;

  // Outcome of one memory access.
  typedef struct packed {
    logic                page_fault;
    logic                writeback;
    logic                evicted_valid;
    logic [EVPAGE_W-1:0] evicted_page;
    logic [COUNT_W-1:0]  fault_count;
    logic [COUNT_W-1:0]  read_count;
    logic [COUNT_W-1:0]  write_count;
  } out_item_t;

  // Increment that sticks at the all-ones value.
  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] res;
    res = (v == '1) ? v : v + COUNT_W'(1);
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/lrup_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module lrup_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lru_page_replacement_core.sv
// Top level of the fully associative LRU page replacement core.
`default_nettype none
// An access is taken when start is high and busy is low; the core then walks
// the resident frames one per cycle through the single read port of the frame
// table, looking for the page and for the least recently used frame at once,
// and writes the frame back in a final update cycle. The scan covers the
// lesser of the resident frames and the usable frames, where the usable
// frames are frames_in_use held to 1..MAX_FRAMES; it is skipped while no
// frame is resident yet.
// The result appears on out_data for exactly one cycle with out_valid high and
// cannot be stalled, so the receiver must take it in that cycle. Frames fill
// from frame 0 upwards and are never freed, so a fill count marks the resident
// frames and no clearing pass is needed after reset.
module lru_page_replacement_core #(
  parameter int MAX_FRAMES = 64,
  parameter int PAGE_BITS  = 12
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Access channel
  input  wire logic                                start,
  output logic                                     busy,
  input  wire lrup_pkg::in_item_t                  in_data,
  // Result channel
  output logic                                     out_valid,
  output lrup_pkg::out_item_t                      out_data,
  // Configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [lrup_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [lrup_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic      [lrup_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                     pready
);

  localparam int TAG_W  = 32 - PAGE_BITS;
  localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W  = (CNT_W > lrup_pkg::FRAMES_W) ? CNT_W : lrup_pkg::FRAMES_W;
  localparam int WORD_W = 32 + 1 + TAG_W;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_LAST = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  logic [CNT_W-1:0]             scan_r, scan_nxt;
  logic [CNT_W-1:0]             n_r, n_nxt;
  logic [CNT_W-1:0]             limit_r, limit_nxt;
  logic [CNT_W-1:0]             fill_r, fill_nxt;
  logic [TAG_W-1:0]             page_r, page_nxt;
  logic                         wr_r, wr_nxt;
  logic [31:0]                  now_r, now_nxt;
  logic                         rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]             rd_idx_r, rd_idx_nxt;
  logic                         hit_r, hit_nxt;
  logic [IDX_W-1:0]             hit_idx_r, hit_idx_nxt;
  logic                         hit_dirty_r, hit_dirty_nxt;
  logic                         vic_vld_r, vic_vld_nxt;
  logic [IDX_W-1:0]             vic_idx_r, vic_idx_nxt;
  logic [TAG_W-1:0]             vic_page_r, vic_page_nxt;
  logic                         vic_dirty_r, vic_dirty_nxt;
  logic [31:0]                  best_age_r, best_age_nxt;
  logic [31:0]                  acc_r, acc_nxt;
  logic [lrup_pkg::COUNT_W-1:0] faults_r, faults_nxt;
  logic [lrup_pkg::COUNT_W-1:0] reads_r, reads_nxt;
  logic [lrup_pkg::COUNT_W-1:0] writes_r, writes_nxt;
  logic [lrup_pkg::FRAMES_W-1:0] frames_r, frames_nxt;
  lrup_pkg::out_item_t          out_r, out_nxt;
  logic                         out_valid_r, out_valid_nxt;

  logic [CMP_W-1:0]  cfg_ext;
  logic [CMP_W-1:0]  lim_wide;
  logic [CNT_W-1:0]  limit_c;
  logic [TAG_W-1:0]  in_page;
  logic              accept;
  logic              cfg_wr;
  logic              free_slot;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  logic [31:0]       rd_stamp;
  logic              rd_dirty;
  logic [TAG_W-1:0]  rd_page;
  logic [31:0]       rd_age;

  // Frame table: stamp, dirty flag and page tag of each frame in one word.
  lrup_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_FRAMES)
  ) u_frames (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_stamp = ram_rdata[WORD_W-1 -: 32];
  assign rd_dirty = ram_rdata[TAG_W];
  assign rd_page  = ram_rdata[TAG_W-1:0];
  assign rd_age   = now_r - rd_stamp;

  // Handshake and configuration decode.
  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign in_page   = in_data.address[31:PAGE_BITS];
  assign free_slot = (fill_r < limit_r);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Register read-back.
  always_comb begin
    prdata = '0;
    if (paddr[2] == lrup_pkg::REG_FRAMES_IN_USE) begin
      prdata = lrup_pkg::CFG_DATA_W'(frames_r);
    end
  end

  // Clamp the configured frame count to 1..MAX_FRAMES.
  always_comb begin
    cfg_ext = CMP_W'(frames_r);
    if (cfg_ext == '0) begin
      lim_wide = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(MAX_FRAMES)) begin
      lim_wide = CMP_W'(MAX_FRAMES);
    end else begin
      lim_wide = cfg_ext;
    end
    limit_c = CNT_W'(lim_wide);
  end

  // Sequencer, scan compare unit and update logic.
  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    n_nxt         = n_r;
    limit_nxt     = limit_r;
    fill_nxt      = fill_r;
    page_nxt      = page_r;
    wr_nxt        = wr_r;
    now_nxt       = now_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_dirty_nxt = hit_dirty_r;
    vic_vld_nxt   = vic_vld_r;
    vic_idx_nxt   = vic_idx_r;
    vic_page_nxt  = vic_page_r;
    vic_dirty_nxt = vic_dirty_r;
    best_age_nxt  = best_age_r;
    acc_nxt       = acc_r;
    faults_nxt    = faults_r;
    reads_nxt     = reads_r;
    writes_nxt    = writes_r;
    frames_nxt    = frames_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = hit_idx_r;
    ram_wdata     = {now_r, wr_r, page_r};

    if (cfg_wr && (paddr[2] == lrup_pkg::REG_FRAMES_IN_USE)) begin
      frames_nxt = pwdata[lrup_pkg::FRAMES_W-1:0];
    end

    // Compare one frame read from the table against the page and the oldest age.
    if (rd_vld_r) begin
      if (!hit_r && (rd_page == page_r)) begin
        hit_nxt       = 1'b1;
        hit_idx_nxt   = rd_idx_r;
        hit_dirty_nxt = rd_dirty;
      end
      if (!vic_vld_r || (rd_age > best_age_r)) begin
        vic_vld_nxt   = 1'b1;
        vic_idx_nxt   = rd_idx_r;
        vic_page_nxt  = rd_page;
        vic_dirty_nxt = rd_dirty;
        best_age_nxt  = rd_age;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          page_nxt    = in_page;
          wr_nxt      = in_data.is_write;
          now_nxt     = acc_r;
          limit_nxt   = limit_c;
          n_nxt       = (fill_r < limit_c) ? fill_r : limit_c;
          scan_nxt    = '0;
          hit_nxt     = 1'b0;
          vic_vld_nxt = 1'b0;
          state_nxt   = (fill_r == '0) ? ST_UPD : ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_vld_nxt = 1'b1;
        rd_idx_nxt = scan_r[IDX_W-1:0];
        scan_nxt   = scan_r + CNT_W'(1);
        if (scan_r == n_r - CNT_W'(1)) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        ram_we                = 1'b1;
        out_nxt.page_fault    = 1'b0;
        out_nxt.writeback     = 1'b0;
        out_nxt.evicted_valid = 1'b0;
        out_nxt.evicted_page  = '0;
        if (hit_r) begin
          ram_waddr = hit_idx_r;
          ram_wdata = {now_r, hit_dirty_r | wr_r, page_r};
        end else begin
          out_nxt.page_fault = 1'b1;
          faults_nxt = lrup_pkg::sat_inc(faults_r);
          reads_nxt  = lrup_pkg::sat_inc(reads_r);
          if (free_slot) begin
            ram_waddr = fill_r[IDX_W-1:0];
            fill_nxt  = fill_r + CNT_W'(1);
          end else begin
            ram_waddr             = vic_idx_r;
            out_nxt.evicted_valid = 1'b1;
            out_nxt.evicted_page  = lrup_pkg::EVPAGE_W'(vic_page_r);
            if (vic_dirty_r) begin
              out_nxt.writeback = 1'b1;
              writes_nxt = lrup_pkg::sat_inc(writes_r);
            end
          end
        end
        out_nxt.fault_count = out_nxt.page_fault ? lrup_pkg::sat_inc(faults_r) : faults_r;
        out_nxt.read_count  = out_nxt.page_fault ? lrup_pkg::sat_inc(reads_r) : reads_r;
        out_nxt.write_count = out_nxt.writeback ? lrup_pkg::sat_inc(writes_r) : writes_r;
        acc_nxt       = acc_r + 32'd1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      vic_vld_r   <= 1'b0;
      acc_r       <= '0;
      faults_r    <= '0;
      reads_r     <= '0;
      writes_r    <= '0;
      frames_r    <= lrup_pkg::FRAMES_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      rd_vld_r    <= rd_vld_nxt;
      hit_r       <= hit_nxt;
      vic_vld_r   <= vic_vld_nxt;
      acc_r       <= acc_nxt;
      faults_r    <= faults_nxt;
      reads_r     <= reads_nxt;
      writes_r    <= writes_nxt;
      frames_r    <= frames_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    scan_r      <= scan_nxt;
    n_r         <= n_nxt;
    limit_r     <= limit_nxt;
    page_r      <= page_nxt;
    wr_r        <= wr_nxt;
    now_r       <= now_nxt;
    rd_idx_r    <= rd_idx_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_dirty_r <= hit_dirty_nxt;
    vic_idx_r   <= vic_idx_nxt;
    vic_page_r  <= vic_page_nxt;
    vic_dirty_r <= vic_dirty_nxt;
    best_age_r  <= best_age_nxt;
    out_r       <= out_nxt;
  end

`ifndef NO_ASSERTIONS
  // A result transfer only follows an update cycle.
  a_out_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_UPD))
    else $error("result strobe without an update cycle");

  // Frame table reads only return while the scan is running.
  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == ST_SCAN || state_r == ST_LAST))
    else $error("frame read outside the scan");

  // A miss with no free frame always has a victim chosen.
  a_victim_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD && !hit_r && !free_slot) |-> vic_vld_r)
    else $error("eviction without a victim");

  // The fill count never passes the frame table depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(MAX_FRAMES))
    else $error("fill count beyond the frame table");
`endif

endmodule
`default_nettype wire
